// ----- src/gfa_pkg.sv -----
// Shared constants and codes for the gas and flame alarm controller.
`default_nettype none

package gfa_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_TEST   = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WARN_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_DELTA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZER_MUTE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_LAMP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_DURATION  = 3'd6;

    // Field widths
    localparam int LEVEL_W = 12;
    localparam int DUR_W   = 16;
    localparam int TONE_W  = 12;
    localparam int TICK_W  = 10;
    localparam int STEP_W  = 5;
    localparam int HOUR_W  = 5;
    localparam int AVG_W   = 12;

    // Register reset values
    localparam logic [LEVEL_W-1:0] WARN_LEVEL_RST     = 12'd1500;
    localparam logic [LEVEL_W-1:0] CRITICAL_LEVEL_RST = 12'd2000;
    localparam logic [LEVEL_W-1:0] CLEAR_LEVEL_RST    = 12'd1000;
    localparam logic [LEVEL_W-1:0] REPORT_DELTA_RST   = 12'd50;
    localparam logic [DUR_W-1:0]   TEST_DURATION_RST  = 16'd8000;

    // Buzzer timing and tones
    localparam logic [TICK_W-1:0] TICK_SAT       = 10'd1023;
    localparam logic [TICK_W-1:0] SIREN_PERIOD   = 10'd100;
    localparam logic [TICK_W-1:0] BEEP_PERIOD    = 10'd500;
    localparam logic [STEP_W-1:0] SIREN_LAST     = 5'd19;
    localparam logic [TONE_W-1:0] SIREN_BASE_HZ  = 12'd1000;
    localparam logic [TONE_W-1:0] SIREN_STEP_HZ  = 12'd100;
    localparam logic [TONE_W-1:0] BEEP_HZ        = 12'd2000;
    localparam logic [TONE_W-1:0] SIREN_MAX_HZ   = 12'd2900;

    // Night window for the lamp
    localparam logic [HOUR_W-1:0] NIGHT_START = 5'd18;
    localparam logic [HOUR_W-1:0] NIGHT_END   = 5'd6;

    // Result word: 34 bits of fields padded to 40
    localparam int OUT_DATA_W = 40;

endpackage

`default_nettype wire

// ----- src/gfa_filter.sv -----
// Moving average filter: sample ring, running sum and reciprocal divide.
`default_nettype none

module gfa_filter #(
    parameter int FILTER_DEPTH = 5,
    parameter int ADC_BITS     = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic [ADC_BITS-1:0] raw,
    output logic      [ADC_BITS-1:0] mean
);

    localparam int DEP_W  = $clog2(FILTER_DEPTH);
    localparam int IDX_W  = (FILTER_DEPTH > 1) ? DEP_W : 1;
    localparam int SUM_W  = ADC_BITS + DEP_W;
    localparam int SHIFT  = SUM_W + DEP_W;
    localparam int M_W    = SUM_W + 1;
    localparam int PROD_W = SUM_W + M_W;
    // ceil(2^SHIFT / depth): exact floor division for any sum below 2^SUM_W
    localparam longint unsigned RECIP_VAL =
        ((longint'(1) << SHIFT) + FILTER_DEPTH - 1) / FILTER_DEPTH;
    localparam logic [M_W-1:0]   RECIP    = M_W'(RECIP_VAL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_DEPTH - 1);

    logic [ADC_BITS-1:0] ring_reg [FILTER_DEPTH];
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [ADC_BITS-1:0] mean_reg;
    logic [PROD_W-1:0]   prod;
    logic [ADC_BITS-1:0] mean_calc;

    // Running sum: drop the oldest entry, add the new reading
    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(raw);
        idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        prod      = PROD_W'(sum_next) * PROD_W'(RECIP);
        mean_calc = prod[SHIFT +: ADC_BITS];
        mean      = push ? mean_calc : mean_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            idx_reg  <= '0;
            sum_reg  <= '0;
            mean_reg <= '0;
        end
        else if (push)
        begin
            ring_reg[idx_reg] <= raw;
            idx_reg           <= idx_next;
            sum_reg           <= sum_next;
            mean_reg          <= mean_calc;
        end
    end

endmodule

`default_nettype wire

// ----- src/gas_flame_alarm_controller.sv -----
// Top level of the gas and flame alarm controller.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser: opcode; s_tdata: gas_raw, flame_seen,
//                                     hour, hour_valid
//  m_*       out  m_tvalid/m_tready  m_tdata: result fields, one per input item
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; each item passes the input
// register, then the result register. The filter divide is a single constant
// multiply on the running sum between those registers.
// Reset clears all alarm state, the sample ring and config to defaults.
// With m_tready low the result holds and the input register still takes one
// more transaction before s_tready drops.
`default_nettype none

module gas_flame_alarm_controller
    import gfa_pkg::*;
#(
    parameter int FILTER_DEPTH = 5,
    parameter int ADC_BITS     = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // opcode[1:0]
    input  wire logic [1:0]            s_tuser,
    // gas_raw, flame_seen, hour[4:0], hour_valid; zero padded to bytes
    input  wire logic [(ADC_BITS + 14) / 8 * 8 - 1:0] s_tdata,
    // Results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tone_hz[11:0], buzzer_on, stop_relay_on, lamp_on, gas_warning,
    // crit_alarm, flame_alarm, gas_alert_event, fire_alert_event,
    // gas_average[11:0], report_gas, reset_accepted; zero padded
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // Configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W     = (ADC_BITS > LEVEL_W) ? ADC_BITS : LEVEL_W;

    // Configuration registers
    logic [LEVEL_W-1:0] warn_level_reg;
    logic [LEVEL_W-1:0] critical_level_reg;
    logic [LEVEL_W-1:0] clear_level_reg;
    logic [LEVEL_W-1:0] report_delta_reg;
    logic               buzzer_mute_reg;
    logic               auto_lamp_reg;
    logic [DUR_W-1:0]   test_duration_reg;

    // Input register
    logic                in_vld_reg;
    logic [1:0]          in_op_reg;
    logic [ADC_BITS-1:0] in_raw_reg;
    logic                in_flame_reg;
    logic [HOUR_W-1:0]   in_hour_reg;
    logic                in_hv_reg;

    // Alarm state
    logic warn_reg, warn_next;
    logic crit_reg, crit_next;
    logic flame_reg, flame_next;
    logic gas_sent_reg, gas_sent_next;
    logic fire_sent_reg, fire_sent_next;
    logic stop_reg, stop_next;
    logic lamp_reg, lamp_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic [TONE_W-1:0]   tone_reg, tone_next;
    logic [DUR_W-1:0]    test_rem_reg, test_rem_next;
    logic [ADC_BITS-1:0] last_rep_reg, last_rep_next;
    logic                rep_valid_reg, rep_valid_next;

    // Result register
    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                in_take;
    logic                advance;
    logic                push;
    logic [ADC_BITS-1:0] mean;
    logic                gas_ev;
    logic                fire_ev;
    logic                report;
    logic                accepted;
    logic [TICK_W-1:0]   ticks_inc;
    logic [STEP_W-1:0]   step_siren;
    logic [STEP_W-1:0]   step_beep;
    logic [CMP_W-1:0]    avg_ext;
    logic [ADC_BITS-1:0] rep_diff;
    logic                is_night;

    // Handshake: the input stage empties whenever the result stage can load
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || !out_vld_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;
    assign push     = advance && (in_op_reg == OP_SAMPLE || in_op_reg == OP_RESET);

    gfa_filter #(
        .FILTER_DEPTH (FILTER_DEPTH),
        .ADC_BITS     (ADC_BITS)
    ) u_filter (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .raw   (in_raw_reg),
        .mean  (mean)
    );

    // Configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_level_reg     <= WARN_LEVEL_RST;
            critical_level_reg <= CRITICAL_LEVEL_RST;
            clear_level_reg    <= CLEAR_LEVEL_RST;
            report_delta_reg   <= REPORT_DELTA_RST;
            buzzer_mute_reg    <= 1'b0;
            auto_lamp_reg      <= 1'b1;
            test_duration_reg  <= TEST_DURATION_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WARN_LEVEL:     warn_level_reg     <= cfg_data[LEVEL_W-1:0];
                REG_CRITICAL_LEVEL: critical_level_reg <= cfg_data[LEVEL_W-1:0];
                REG_CLEAR_LEVEL:    clear_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_REPORT_DELTA:   report_delta_reg   <= cfg_data[LEVEL_W-1:0];
                REG_BUZZER_MUTE:    buzzer_mute_reg    <= cfg_data[0];
                REG_AUTO_LAMP:      auto_lamp_reg      <= cfg_data[0];
                REG_TEST_DURATION:  test_duration_reg  <= cfg_data[DUR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= s_tuser;
            in_raw_reg   <= s_tdata[ADC_BITS-1:0];
            in_flame_reg <= s_tdata[ADC_BITS];
            in_hour_reg  <= s_tdata[ADC_BITS+1 +: HOUR_W];
            in_hv_reg    <= s_tdata[ADC_BITS+1+HOUR_W];
        end
    end

    // Item processing
    always_comb
    begin
        warn_next      = warn_reg;
        crit_next      = crit_reg;
        flame_next     = flame_reg;
        gas_sent_next  = gas_sent_reg;
        fire_sent_next = fire_sent_reg;
        stop_next      = stop_reg;
        lamp_next      = lamp_reg;
        step_next      = step_reg;
        ticks_next     = ticks_reg;
        tone_next      = tone_reg;
        test_rem_next  = test_rem_reg;
        last_rep_next  = last_rep_reg;
        rep_valid_next = rep_valid_reg;
        gas_ev         = 1'b0;
        fire_ev        = 1'b0;
        report         = 1'b0;
        accepted       = 1'b0;

        ticks_inc  = (ticks_reg < TICK_SAT) ? ticks_reg + 1'b1 : ticks_reg;
        step_siren = (step_reg >= SIREN_LAST) ? '0 : step_reg + 1'b1;
        step_beep  = (step_reg != '0) ? '0 : STEP_W'(1);
        avg_ext    = CMP_W'(mean);
        rep_diff   = (mean > last_rep_reg) ? mean - last_rep_reg : last_rep_reg - mean;
        is_night   = (in_hour_reg >= NIGHT_START) || (in_hour_reg < NIGHT_END);

        if (advance)
        begin
            unique case (in_op_reg)
                OP_TICK:
                begin
                    ticks_next = ticks_inc;
                    if (buzzer_mute_reg)
                    begin
                        tone_next = '0;
                    end
                    else if (crit_reg || flame_reg || test_rem_reg != '0)
                    begin
                        if (ticks_inc >= SIREN_PERIOD)
                        begin
                            ticks_next = '0;
                            step_next  = step_siren;
                            tone_next  = SIREN_BASE_HZ + TONE_W'(step_siren) * SIREN_STEP_HZ;
                        end
                    end
                    else if (warn_reg)
                    begin
                        if (ticks_inc >= BEEP_PERIOD)
                        begin
                            ticks_next = '0;
                            step_next  = step_beep;
                            tone_next  = (step_beep != '0) ? BEEP_HZ : '0;
                        end
                    end
                    else
                    begin
                        tone_next = '0;
                    end
                    if (test_rem_reg != '0)
                    begin
                        test_rem_next = test_rem_reg - 1'b1;
                    end
                end
                OP_SAMPLE:
                begin
                    warn_next = (avg_ext > CMP_W'(warn_level_reg)) &&
                                (avg_ext <= CMP_W'(critical_level_reg));
                    crit_next = avg_ext > CMP_W'(critical_level_reg);
                    // Gas band: relay and one-shot event
                    if (crit_next)
                    begin
                        stop_next = 1'b1;
                        if (!gas_sent_reg)
                        begin
                            gas_ev        = 1'b1;
                            gas_sent_next = 1'b1;
                        end
                    end
                    else
                    begin
                        gas_sent_next = 1'b0;
                        if (!flame_reg)
                        begin
                            stop_next = 1'b0;
                        end
                    end
                    // Flame
                    if (in_flame_reg)
                    begin
                        flame_next = 1'b1;
                        stop_next  = 1'b1;
                        lamp_next  = 1'b1;
                        if (!fire_sent_reg)
                        begin
                            fire_ev        = 1'b1;
                            fire_sent_next = 1'b1;
                        end
                    end
                    else
                    begin
                        flame_next     = 1'b0;
                        fire_sent_next = 1'b0;
                    end
                    // Lamp by hour of day
                    if (in_hv_reg && auto_lamp_reg)
                    begin
                        lamp_next = is_night;
                    end
                    // Report when the average moved beyond the delta
                    if (!rep_valid_reg || CMP_W'(rep_diff) > CMP_W'(report_delta_reg))
                    begin
                        report         = 1'b1;
                        last_rep_next  = mean;
                        rep_valid_next = 1'b1;
                    end
                end
                OP_RESET:
                begin
                    if (!in_flame_reg && avg_ext < CMP_W'(clear_level_reg))
                    begin
                        warn_next  = 1'b0;
                        crit_next  = 1'b0;
                        flame_next = 1'b0;
                        stop_next  = 1'b0;
                        tone_next  = '0;
                        accepted   = 1'b1;
                    end
                end
                OP_TEST:
                begin
                    test_rem_next = test_duration_reg;
                end
            endcase
        end

        out_data_next = {6'b0, accepted, report, AVG_W'(mean), fire_ev, gas_ev,
                         flame_next, crit_next, warn_next, lamp_next, stop_next,
                         tone_next != '0, tone_next};
    end

    // Alarm state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg      <= 1'b0;
            crit_reg      <= 1'b0;
            flame_reg     <= 1'b0;
            gas_sent_reg  <= 1'b0;
            fire_sent_reg <= 1'b0;
            stop_reg      <= 1'b0;
            lamp_reg      <= 1'b0;
            step_reg      <= '0;
            ticks_reg     <= '0;
            tone_reg      <= '0;
            test_rem_reg  <= '0;
            last_rep_reg  <= '0;
            rep_valid_reg <= 1'b0;
        end
        else
        begin
            warn_reg      <= warn_next;
            crit_reg      <= crit_next;
            flame_reg     <= flame_next;
            gas_sent_reg  <= gas_sent_next;
            fire_sent_reg <= fire_sent_next;
            stop_reg      <= stop_next;
            lamp_reg      <= lamp_next;
            step_reg      <= step_next;
            ticks_reg     <= ticks_next;
            tone_reg      <= tone_next;
            test_rem_reg  <= test_rem_next;
            last_rep_reg  <= last_rep_next;
            rep_valid_reg <= rep_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Siren step never leaves its 20-step range
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SIREN_LAST)
        else $error("siren step out of range");

    // Tone is silent, the beep, or a siren step
    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        tone_reg == '0 || (tone_reg >= SIREN_BASE_HZ && tone_reg <= SIREN_MAX_HZ))
        else $error("tone out of range");

    // Any active gas-critical or flame alarm holds the stop relay
    a_stop_relay: assert property (@(posedge clk) disable iff (!rst_n)
        (crit_reg || flame_reg) |-> stop_reg)
        else $error("alarm active with stop relay released");

    // Warning and critical bands are exclusive
    a_bands: assert property (@(posedge clk) disable iff (!rst_n)
        !(warn_reg && crit_reg))
        else $error("warning and critical both set");

    // An alert event goes out only with its alarm set in the same result
    a_events: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (!m_tdata[18] || m_tdata[16]) && (!m_tdata[19] || m_tdata[17]))
        else $error("alert event without its alarm");
`endif

endmodule

`default_nettype wire

// ----- tb/gas_flame_alarm_controller_test.sv -----
// Self-checking stream testbench for the gas and flame alarm controller.
module gas_flame_alarm_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gfa_pkg::*;

    localparam int IN_DATA_W   = 24;
    localparam int RING_DEPTH  = 5;
    localparam int CYCLE_LIMIT = 400000;

    // Result fields, tone_hz in the low bits of m_tdata
    typedef struct packed {
        logic              reset_accepted;
        logic              report_gas;
        logic [AVG_W-1:0]  gas_average;
        logic              fire_alert_event;
        logic              gas_alert_event;
        logic              flame_alarm;
        logic              crit_alarm;
        logic              gas_warning;
        logic              lamp_on;
        logic              stop_relay_on;
        logic              buzzer_on;
        logic [TONE_W-1:0] tone_hz;
    } alarm_status_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // opcode[1:0]
    logic [1:0]            s_tuser   = OP_TICK;
    // gas_raw[11:0], flame_seen, hour[4:0], hour_valid, zero padding
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // tone_hz[11:0], buzzer_on, stop_relay_on, lamp_on, gas_warning, crit_alarm,
    // flame_alarm, gas_alert_event, fire_alert_event, gas_average[11:0],
    // report_gas, reset_accepted, zero padding
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WARN_LEVEL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Run control
    int  fail_count  = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  idle_en     = 1'b0;

    // Register mirror
    logic [LEVEL_W-1:0] warn_lvl   = WARN_LEVEL_RST;
    logic [LEVEL_W-1:0] crit_lvl   = CRITICAL_LEVEL_RST;
    logic [LEVEL_W-1:0] clear_lvl  = CLEAR_LEVEL_RST;
    logic [LEVEL_W-1:0] delta_lvl  = REPORT_DELTA_RST;
    logic               mute_on    = 1'b0;
    logic               lamp_auto  = 1'b1;
    logic [DUR_W-1:0]   test_len   = TEST_DURATION_RST;

    // Alarm state mirror
    logic [AVG_W-1:0]  readings [RING_DEPTH] = '{default: '0};
    int                next_slot       = 0;
    logic              warn_on         = 1'b0;
    logic              crit_on         = 1'b0;
    logic              flame_on        = 1'b0;
    logic              gas_event_sent  = 1'b0;
    logic              fire_event_sent = 1'b0;
    logic              stop_on         = 1'b0;
    logic              lamp_relay_on   = 1'b0;
    logic [STEP_W-1:0] tone_step       = '0;
    logic [TICK_W-1:0] since_step      = '0;
    logic [TONE_W-1:0] tone_now        = '0;
    logic [DUR_W-1:0]  test_ticks_left = '0;
    logic [AVG_W-1:0]  last_sent_avg   = '0;
    logic              avg_sent_once   = 1'b0;

    alarm_status_t expected_status [$];

    gas_flame_alarm_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gas_flame_alarm_controller regression: fail");
            $finish;
        end
    end

    // Result side drops m_tready in random bursts while idle_en is set
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Mean of the reading ring, truncated
    function automatic logic [AVG_W-1:0] readings_mean();
        int unsigned sum;
        sum = 0;
        foreach (readings[i])
            sum += readings[i];
        return AVG_W'(sum / RING_DEPTH);
    endfunction

    function automatic logic [AVG_W-1:0] push_reading(input logic [11:0] raw);
        readings[next_slot] = raw;
        next_slot = (next_slot + 1) % RING_DEPTH;
        return readings_mean();
    endfunction

    // Advance the alarm state by one item and queue the status it should produce
    task automatic predict_alarm_status(input logic [1:0] op, input logic [11:0] gas,
                                        input logic flame, input logic [4:0] hour,
                                        input logic hv);
        alarm_status_t st;
        logic [AVG_W-1:0] avg;
        int unsigned diff;
        logic gas_evt, fire_evt, report, accepted;
        gas_evt  = 1'b0;
        fire_evt = 1'b0;
        report   = 1'b0;
        accepted = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (since_step != TICK_SAT)
                    since_step++;
                if (mute_on)
                    tone_now = '0;
                else if (crit_on || flame_on || test_ticks_left != 0)
                begin
                    // stepped siren
                    if (since_step >= SIREN_PERIOD)
                    begin
                        since_step = '0;
                        tone_step  = (tone_step >= SIREN_LAST) ? '0 : tone_step + 1'b1;
                        tone_now   = SIREN_BASE_HZ + SIREN_STEP_HZ * tone_step;
                    end
                end
                else if (warn_on)
                begin
                    // slow on/off beep
                    if (since_step >= BEEP_PERIOD)
                    begin
                        since_step = '0;
                        tone_step  = (tone_step != 0) ? 5'd0 : 5'd1;
                        tone_now   = (tone_step != 0) ? BEEP_HZ : '0;
                    end
                end
                else
                    tone_now = '0;
                if (test_ticks_left != 0)
                    test_ticks_left--;
            end
            OP_SAMPLE:
            begin
                avg     = push_reading(gas);
                warn_on = avg > warn_lvl && avg <= crit_lvl;
                crit_on = avg > crit_lvl;
                if (crit_on)
                begin
                    stop_on = 1'b1;
                    if (!gas_event_sent)
                    begin
                        gas_evt        = 1'b1;
                        gas_event_sent = 1'b1;
                    end
                end
                else
                begin
                    gas_event_sent = 1'b0;
                    // the flame flag from before this sample holds the relay
                    if (!flame_on)
                        stop_on = 1'b0;
                end
                if (flame)
                begin
                    flame_on      = 1'b1;
                    stop_on       = 1'b1;
                    lamp_relay_on = 1'b1;
                    if (!fire_event_sent)
                    begin
                        fire_evt        = 1'b1;
                        fire_event_sent = 1'b1;
                    end
                end
                else
                begin
                    flame_on        = 1'b0;
                    fire_event_sent = 1'b0;
                end
                if (hv && lamp_auto)
                    lamp_relay_on = hour >= NIGHT_START || hour < NIGHT_END;
                diff = (avg > last_sent_avg) ? avg - last_sent_avg : last_sent_avg - avg;
                if (!avg_sent_once || diff > delta_lvl)
                begin
                    report        = 1'b1;
                    last_sent_avg = avg;
                    avg_sent_once = 1'b1;
                end
            end
            OP_RESET:
            begin
                avg = push_reading(gas);
                if (!flame && avg < clear_lvl)
                begin
                    warn_on  = 1'b0;
                    crit_on  = 1'b0;
                    flame_on = 1'b0;
                    stop_on  = 1'b0;
                    tone_now = '0;
                    accepted = 1'b1;
                end
            end
            default:
                test_ticks_left = test_len;
        endcase
        st.tone_hz          = tone_now;
        st.buzzer_on        = tone_now != 0;
        st.stop_relay_on    = stop_on;
        st.lamp_on          = lamp_relay_on;
        st.gas_warning      = warn_on;
        st.crit_alarm       = crit_on;
        st.flame_alarm      = flame_on;
        st.gas_alert_event  = gas_evt;
        st.fire_alert_event = fire_evt;
        st.gas_average      = readings_mean();
        st.report_gas       = report;
        st.reset_accepted   = accepted;
        expected_status.push_back(st);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction with the oldest expected status
    always @(posedge clk)
    begin
        alarm_status_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = alarm_status_t'(m_tdata[$bits(alarm_status_t)-1:0]);
            if (expected_status.size() == 0)
            begin
                $error("result transaction with no expected status pending");
                fail_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("tone_hz", want.tone_hz, got.tone_hz);
                check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
                check_field("stop_relay_on", want.stop_relay_on, got.stop_relay_on);
                check_field("lamp_on", want.lamp_on, got.lamp_on);
                check_field("gas_warning", want.gas_warning, got.gas_warning);
                check_field("crit_alarm", want.crit_alarm, got.crit_alarm);
                check_field("flame_alarm", want.flame_alarm, got.flame_alarm);
                check_field("gas_alert_event", want.gas_alert_event,
                            got.gas_alert_event);
                check_field("fire_alert_event", want.fire_alert_event,
                            got.fire_alert_event);
                check_field("gas_average", want.gas_average, got.gas_average);
                check_field("report_gas", want.report_gas, got.report_gas);
                check_field("reset_accepted", want.reset_accepted, got.reset_accepted);
            end
        end
    end

    // One input transaction, with an optional idle burst in front
    task automatic send_item(input logic [1:0] op, input logic [11:0] gas,
                             input logic flame, input logic [4:0] hour, input logic hv);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, hv, hour, flame, gas};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_alarm_status(op, gas, flame, hour, hv);
    endtask

    // Tick with random don't-care payload
    task automatic send_tick();
        send_item(OP_TICK, 12'($urandom), 1'($urandom), 5'($urandom), 1'($urandom));
    endtask

    // Stop sending and wait until every expected status has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WARN_LEVEL:     warn_lvl  = value[LEVEL_W-1:0];
            REG_CRITICAL_LEVEL: crit_lvl  = value[LEVEL_W-1:0];
            REG_CLEAR_LEVEL:    clear_lvl = value[LEVEL_W-1:0];
            REG_REPORT_DELTA:   delta_lvl = value[LEVEL_W-1:0];
            REG_BUZZER_MUTE:    mute_on   = value[0];
            REG_AUTO_LAMP:      lamp_auto = value[0];
            REG_TEST_DURATION:  test_len  = value[DUR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input int warn, input int crit, input int clear,
                                  input int delta, input bit mute, input bit lamp,
                                  input int dur);
        write_reg(REG_WARN_LEVEL, CFG_DATA_W'(warn));
        write_reg(REG_CRITICAL_LEVEL, CFG_DATA_W'(crit));
        write_reg(REG_CLEAR_LEVEL, CFG_DATA_W'(clear));
        write_reg(REG_REPORT_DELTA, CFG_DATA_W'(delta));
        write_reg(REG_BUZZER_MUTE, CFG_DATA_W'(mute));
        write_reg(REG_AUTO_LAMP, CFG_DATA_W'(lamp));
        write_reg(REG_TEST_DURATION, CFG_DATA_W'(dur));
    endtask

    // Mostly ticks, readings scattered around a center, some resets and tests
    task automatic send_random_item(input int center);
        int unsigned pick;
        int gas;
        logic [1:0] op;
        logic [4:0] hour;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            gas = $urandom_range(0, 4095);
        else
            gas = center + int'($urandom_range(0, 400)) - 200;
        if (gas < 0)
            gas = 0;
        if (gas > 4095)
            gas = 4095;
        hour = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                           : 5'($urandom_range(0, 23));
        if (pick < 72)
            op = OP_TICK;
        else if (pick < 90)
            op = OP_SAMPLE;
        else if (pick < 96)
            op = OP_RESET;
        else
            op = OP_TEST;
        send_item(op, 12'(gas), $urandom_range(0, 9) == 0, hour, $urandom_range(0, 3) != 0);
    endtask

    // Field extremes, events, relays and reset handling at default settings
    task automatic test_directed_items();
        send_item(OP_TICK, 12'd0, 1'b0, 5'd0, 1'b0);
        // first sample always reports
        send_item(OP_SAMPLE, 12'd0, 1'b0, 5'd12, 1'b1);
        // flame with an hour past the clock range counts as night
        send_item(OP_SAMPLE, 12'd4095, 1'b1, 5'd31, 1'b1);
        send_item(OP_SAMPLE, 12'd4095, 1'b1, 5'd6, 1'b1);
        // average crosses critical: single gas event
        send_item(OP_SAMPLE, 12'd4095, 1'b0, 5'd5, 1'b1);
        send_item(OP_SAMPLE, 12'd4095, 1'b0, 5'd18, 1'b0);
        // rejected while the average is high, accepted once it falls
        send_item(OP_RESET, 12'd0, 1'b0, 5'd0, 1'b0);
        send_item(OP_TICK, 12'd4095, 1'b1, 5'd31, 1'b1);
        send_item(OP_RESET, 12'd0, 1'b0, 5'd0, 1'b0);
        send_item(OP_RESET, 12'd0, 1'b0, 5'd0, 1'b0);
        send_item(OP_RESET, 12'd0, 1'b0, 5'd0, 1'b0);
        // flame blocks a reset
        send_item(OP_RESET, 12'd0, 1'b1, 5'd0, 1'b0);
        // stop relay held one sample by the earlier flame flag
        send_item(OP_SAMPLE, 12'd100, 1'b1, 5'd23, 1'b1);
        send_item(OP_SAMPLE, 12'd100, 1'b0, 5'd7, 1'b1);
        send_item(OP_SAMPLE, 12'd100, 1'b0, 5'd7, 1'b1);
        send_item(OP_TEST, 12'd2048, 1'b1, 5'd16, 1'b1);
        send_item(OP_TICK, 12'd0, 1'b0, 5'd0, 1'b0);
        send_item(OP_SAMPLE, 12'd4095, 1'b0, 5'd24, 1'b1);
        send_item(OP_TICK, 12'd4095, 1'b1, 5'd31, 1'b1);
        send_item(OP_RESET, 12'd4095, 1'b1, 5'd31, 1'b1);
    endtask

    // Critical alarm held for a few siren steps
    task automatic test_siren_steps();
        repeat (5)
            send_item(OP_SAMPLE, 12'd3000, 1'b0, 5'($urandom_range(0, 23)), 1'b1);
        repeat (310)
            send_tick();
    endtask

    // Warning band only: the slow beep toggles
    task automatic test_warning_beep();
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd1);
        // a new start reloads the running test alarm with one tick
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        send_tick();
        repeat (5)
            send_item(OP_SAMPLE, 12'd1800, 1'b0, 5'd10, 1'b1);
        repeat (510)
            send_tick();
    endtask

    // Test alarm lengths, including none, the longest, and a muted run
    task automatic test_alarm_durations();
        repeat (5)
            send_item(OP_RESET, 12'd0, 1'b0, 5'd0, 1'b0);
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd0);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        repeat (3)
            send_tick();
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd150);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        repeat (160)
            send_tick();
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd65535);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        repeat (40)
            send_tick();
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd200);
        write_reg(REG_BUZZER_MUTE, 16'd1);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        repeat (120)
            send_tick();
        drain_results();
        write_reg(REG_BUZZER_MUTE, 16'd0);
        repeat (30)
            send_tick();
        drain_results();
        write_reg(REG_TEST_DURATION, 16'd1);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        repeat (2)
            send_tick();
    endtask

    // Level registers at both ends of their range
    task automatic test_register_extremes();
        drain_results();
        apply_settings(0, 4095, 4095, 0, 1'b0, 1'b0, 1);
        repeat (40)
            send_random_item($urandom_range(0, 4095));
        drain_results();
        apply_settings(4095, 0, 0, 4095, 1'b0, 1'b1, 65535);
        repeat (40)
            send_random_item($urandom_range(0, 4095));
        drain_results();
        apply_settings(1500, 2000, 1000, 50, 1'b0, 1'b1, 1);
        send_item(OP_TEST, 12'd0, 1'b0, 5'd0, 1'b0);
        send_tick();
    endtask

    // Random settings per phase, readings drifting between bands
    task automatic test_random_phases(input int phases, input int items_per_phase);
        int center, clear, warn, crit;
        repeat (phases)
        begin
            drain_results();
            if ($urandom_range(0, 3) == 0)
            begin
                clear = $urandom_range(0, 1) ? 4095 : 0;
                warn  = $urandom_range(0, 4095);
                crit  = $urandom_range(0, 1) ? 4095 : 0;
            end
            else
            begin
                clear = $urandom_range(0, 1500);
                warn  = clear + $urandom_range(0, 1500);
                crit  = warn + $urandom_range(0, 4095 - warn);
            end
            apply_settings(warn, crit, clear, $urandom_range(0, 300),
                           $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                           $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 400));
            center = $urandom_range(0, 4095);
            for (int i = 0; i < items_per_phase; i++)
            begin
                if (i % 25 == 24)
                    center = $urandom_range(0, 4095);
                send_random_item(center);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_en = 1'b1;
        test_directed_items();
        test_siren_steps();
        test_warning_beep();
        test_alarm_durations();
        test_register_extremes();
        test_random_phases(4, 80);
        // closing stretch at full rate
        idle_en = 1'b0;
        test_random_phases(2, 60);
        drain_results();
        if (fail_count == 0)
            $display("gas_flame_alarm_controller regression: pass");
        else
            $display("gas_flame_alarm_controller regression: fail");
        $finish;
    end

endmodule

// ----- gas_flame_alarm_controller.f -----
src/gfa_pkg.sv
src/gfa_filter.sv
src/gas_flame_alarm_controller.sv
tb/gas_flame_alarm_controller_test.sv
